### hw/rtl/pdft_pkg.sv
// Shared types and constants for the peer delivery failure tracker.
package pdft_pkg;

   localparam int MAC_W      = 48;
   localparam int STREAK_W   = 8;
   localparam int CMD_W      = 3;
   localparam int MAX_OUT    = 8;
   localparam int TICK_CNT_W = $clog2(MAX_OUT + 1);

   localparam logic [STREAK_W-1:0] THRESHOLD_RESET = 8'd3;

   localparam logic [CMD_W-1:0] CMD_SEND_OK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEND_FAIL  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REGISTERED = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVED    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // control from the sequencer to the slot store
   typedef struct packed {
      logic rd_en;
      logic wr_slot;
      logic wr_pend;
   } mem_ctl_type;

endpackage

### hw/rtl/pdft_slot_mem.sv
// Slot store: peer address, failure streak and recovery flag per slot.
module pdft_slot_mem #(
   parameter int PEER_SLOTS = 8,
   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
   input  logic                            clock,
   input  pdft_pkg::mem_ctl_type           ctl,
   input  logic [IW-1:0]                   rd_idx,
   input  logic [IW-1:0]                   wr_idx,
   input  logic [pdft_pkg::MAC_W-1:0]      wr_mac,
   input  logic [pdft_pkg::STREAK_W-1:0]   wr_streak,
   input  logic                            wr_pend,
   output logic [pdft_pkg::MAC_W-1:0]      rd_mac,
   output logic [pdft_pkg::STREAK_W-1:0]   rd_streak,
   output logic                            rd_pend
);

   logic [pdft_pkg::MAC_W-1:0]    addr_mem   [PEER_SLOTS];
   logic [pdft_pkg::STREAK_W-1:0] streak_mem [PEER_SLOTS];
   logic                          pend_mem   [PEER_SLOTS];

   always_ff @(posedge clock) begin
      if (ctl.wr_slot) begin
         addr_mem[wr_idx]   <= wr_mac;
         streak_mem[wr_idx] <= wr_streak;
      end
      if (ctl.wr_slot || ctl.wr_pend) begin
         pend_mem[wr_idx] <= wr_pend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_mac    <= addr_mem[rd_idx];
         rd_streak <= streak_mem[rd_idx];
         rd_pend   <= pend_mem[rd_idx];
      end
   end

endmodule

### hw/rtl/peer_delivery_failure_tracker_core.sv
// Top level of the peer delivery failure tracker: slot scan sequencer and result register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_command, req_peer_mac
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_request_valid, rsp_recovery_mac,
//          |           |                      | rsp_fail_count, rsp_table_full, rsp_last
//  csr     | in        | csr_valid/csr_ready  | csr_fail_threshold
//
// Every known command walks the slot store one slot per cycle through its single read port
// (unless a tick pauses its scan): accept, PEER_SLOTS reads, a compare of the last read,
// then an update beat, or a final beat for a tick. Unknown commands go to the final beat.
// A beat held under rsp_stall delays the final cycle of any item; a tick also pauses
// its scan while a second flagged peer waits for the result register to be free.
// Reset clears the slot valid bits, the result register and sets the threshold to 3.
// req_stall is high from acceptance until the item's last beat is in the result register.
module peer_delivery_failure_tracker_core #(
   parameter int PEER_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pdft_pkg::CMD_W-1:0]        req_command,
   input  logic [pdft_pkg::MAC_W-1:0]        req_peer_mac,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_request_valid,
   output logic [pdft_pkg::MAC_W-1:0]        rsp_recovery_mac,
   output logic [pdft_pkg::STREAK_W-1:0]     rsp_fail_count,
   output logic                              rsp_table_full,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pdft_pkg::STREAK_W-1:0]     csr_fail_threshold
);

   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CW = $clog2(PEER_SLOTS + 1);

   pdft_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                      issue_ff, issue_in;
   logic                               chk_vld_ff, chk_vld_in;
   logic [IW-1:0]                      chk_idx_ff, chk_idx_in;
   logic [pdft_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic [pdft_pkg::MAC_W-1:0]         mac_ff, mac_in;
   logic                               hit_ff, hit_in;
   logic [IW-1:0]                      hit_idx_ff, hit_idx_in;
   logic [pdft_pkg::STREAK_W-1:0]      hit_streak_ff, hit_streak_in;
   logic                               hit_pend_ff, hit_pend_in;
   logic                               free_ff, free_in;
   logic [IW-1:0]                      free_idx_ff, free_idx_in;
   logic                               hold_vld_ff, hold_vld_in;
   logic [pdft_pkg::MAC_W-1:0]         hold_mac_ff, hold_mac_in;
   logic [pdft_pkg::TICK_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pdft_pkg::STREAK_W-1:0]      thr_ff, thr_in;
   logic [PEER_SLOTS-1:0]              valid_ff, valid_in;

   logic                               out_vld_ff, out_vld_in;
   logic                               out_req_ff, out_req_in;
   logic [pdft_pkg::MAC_W-1:0]         out_mac_ff, out_mac_in;
   logic [pdft_pkg::STREAK_W-1:0]      out_cnt_ff, out_cnt_in;
   logic                               out_full_ff, out_full_in;
   logic                               out_last_ff, out_last_in;

   // memory side
   pdft_pkg::mem_ctl_type              mem_ctl;
   logic [IW-1:0]                      wr_idx;
   logic [pdft_pkg::STREAK_W-1:0]      wr_streak;
   logic                               wr_pend;
   logic [pdft_pkg::MAC_W-1:0]         rd_mac;
   logic [pdft_pkg::STREAK_W-1:0]      rd_streak;
   logic                               rd_pend;

   // beat push into the result register
   logic                               push;
   logic                               p_req;
   logic [pdft_pkg::MAC_W-1:0]         p_mac;
   logic [pdft_pkg::STREAK_W-1:0]      p_cnt;
   logic                               p_full;
   logic                               p_last;

   logic                               out_free;
   logic                               is_tick;
   logic                               known_cmd;
   logic                               slot_on;
   logic                               tick_flag;
   logic                               adv;
   logic                               scan_done;
   logic [IW-1:0]                      upd_idx;
   logic [pdft_pkg::STREAK_W-1:0]      base_streak;
   logic                               base_pend;
   logic [pdft_pkg::STREAK_W-1:0]      inc_streak;

   pdft_slot_mem #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_slot_mem (
      .clock     (clock),
      .ctl       (mem_ctl),
      .rd_idx    (issue_ff[IW-1:0]),
      .wr_idx    (wr_idx),
      .wr_mac    (mac_ff),
      .wr_streak (wr_streak),
      .wr_pend   (wr_pend),
      .rd_mac    (rd_mac),
      .rd_streak (rd_streak),
      .rd_pend   (rd_pend)
   );

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign is_tick   = (cmd_ff == pdft_pkg::CMD_TICK);
   assign known_cmd = (req_command == pdft_pkg::CMD_SEND_OK)
                   || (req_command == pdft_pkg::CMD_SEND_FAIL)
                   || (req_command == pdft_pkg::CMD_REGISTERED)
                   || (req_command == pdft_pkg::CMD_REMOVED)
                   || (req_command == pdft_pkg::CMD_TICK);
   assign slot_on   = valid_ff[chk_idx_ff];
   assign tick_flag = is_tick && chk_vld_ff && slot_on && rd_pend
                   && (cnt_ff < pdft_pkg::TICK_CNT_W'(pdft_pkg::MAX_OUT));
   // a flagged peer with a request already held needs a free result register
   assign adv       = !(tick_flag && hold_vld_ff && !out_free);
   assign scan_done = (issue_ff == CW'(PEER_SLOTS)) && !chk_vld_ff;

   assign upd_idx     = hit_ff ? hit_idx_ff : free_idx_ff;
   assign base_streak = hit_ff ? hit_streak_ff : '0;
   assign base_pend   = hit_ff && hit_pend_ff;
   assign inc_streak  = base_streak + pdft_pkg::STREAK_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdft_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = known_cmd ? pdft_pkg::ST_SCAN : pdft_pkg::ST_FINISH;
            end
         end
         pdft_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = is_tick ? pdft_pkg::ST_FINISH : pdft_pkg::ST_UPDATE;
            end
         end
         pdft_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = pdft_pkg::ST_IDLE;
            end
         end
         pdft_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = pdft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdft_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      issue_in      = issue_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      cmd_in        = cmd_ff;
      mac_in        = mac_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_streak_in = hit_streak_ff;
      hit_pend_in   = hit_pend_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      hold_vld_in   = hold_vld_ff;
      hold_mac_in   = hold_mac_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      mem_ctl       = '0;
      wr_idx        = chk_idx_ff;
      wr_streak     = '0;
      wr_pend       = 1'b0;
      push          = 1'b0;
      p_req         = 1'b0;
      p_mac         = '0;
      p_cnt         = '0;
      p_full        = 1'b0;
      p_last        = 1'b1;
      req_stall     = 1'b1;

      case (state_ff)
         pdft_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in      = req_command;
               mac_in      = req_peer_mac;
               issue_in    = '0;
               chk_vld_in  = 1'b0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               hold_vld_in = 1'b0;
               cnt_in      = '0;
            end
         end
         pdft_pkg::ST_SCAN: begin
            if (adv) begin
               if (issue_ff != CW'(PEER_SLOTS)) begin
                  mem_ctl.rd_en = 1'b1;
                  chk_vld_in    = 1'b1;
                  chk_idx_in    = issue_ff[IW-1:0];
                  issue_in      = issue_ff + CW'(1);
               end else begin
                  chk_vld_in = 1'b0;
               end
               if (chk_vld_ff && !is_tick) begin
                  if (slot_on && (rd_mac == mac_ff) && !hit_ff) begin
                     hit_in        = 1'b1;
                     hit_idx_in    = chk_idx_ff;
                     hit_streak_in = rd_streak;
                     hit_pend_in   = rd_pend;
                  end
                  if (!slot_on && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end
               if (tick_flag) begin
                  // clear the flag, hold this request until the next one shows up or the scan finishes
                  mem_ctl.wr_pend = 1'b1;
                  wr_pend         = 1'b0;
                  hold_vld_in     = 1'b1;
                  hold_mac_in     = rd_mac;
                  cnt_in          = cnt_ff + pdft_pkg::TICK_CNT_W'(1);
                  if (hold_vld_ff) begin
                     push   = 1'b1;
                     p_req  = 1'b1;
                     p_mac  = hold_mac_ff;
                     p_last = 1'b0;
                  end
               end
            end
         end
         pdft_pkg::ST_UPDATE: begin
            if (out_free) begin
               push = 1'b1;
               if (cmd_ff == pdft_pkg::CMD_REMOVED) begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
               end else if (!hit_ff && !free_ff) begin
                  p_full = 1'b1;
               end else begin
                  wr_idx           = upd_idx;
                  mem_ctl.wr_slot  = 1'b1;
                  valid_in[upd_idx] = 1'b1;
                  case (cmd_ff)
                     pdft_pkg::CMD_SEND_FAIL: begin
                        if (inc_streak >= thr_ff) begin
                           wr_streak = '0;
                           wr_pend   = 1'b1;
                        end else begin
                           wr_streak = inc_streak;
                           wr_pend   = base_pend;
                        end
                     end
                     pdft_pkg::CMD_REGISTERED: begin
                        wr_streak = '0;
                        wr_pend   = 1'b0;
                     end
                     default: begin
                        wr_streak = '0;
                        wr_pend   = base_pend;
                     end
                  endcase
                  p_cnt = wr_streak;
               end
            end
         end
         pdft_pkg::ST_FINISH: begin
            if (out_free) begin
               push  = 1'b1;
               p_req = hold_vld_ff;
               p_mac = hold_vld_ff ? hold_mac_ff : '0;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // result register
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_req_in  = out_req_ff;
      out_mac_in  = out_mac_ff;
      out_cnt_in  = out_cnt_ff;
      out_full_in = out_full_ff;
      out_last_in = out_last_ff;
      if (push) begin
         out_vld_in  = 1'b1;
         out_req_in  = p_req;
         out_mac_in  = p_mac;
         out_cnt_in  = p_cnt;
         out_full_in = p_full;
         out_last_in = p_last;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   assign csr_ready = 1'b1;
   assign thr_in    = csr_valid ? csr_fail_threshold : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pdft_pkg::ST_IDLE;
         valid_ff    <= '0;
         out_vld_ff  <= 1'b0;
         thr_ff      <= pdft_pkg::THRESHOLD_RESET;
         hold_vld_ff <= 1'b0;
         chk_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         issue_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         out_vld_ff  <= out_vld_in;
         thr_ff      <= thr_in;
         hold_vld_ff <= hold_vld_in;
         chk_vld_ff  <= chk_vld_in;
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         issue_ff    <= issue_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      cmd_ff        <= cmd_in;
      mac_ff        <= mac_in;
      hit_idx_ff    <= hit_idx_in;
      hit_streak_ff <= hit_streak_in;
      hit_pend_ff   <= hit_pend_in;
      free_idx_ff   <= free_idx_in;
      hold_mac_ff   <= hold_mac_in;
      out_req_ff    <= out_req_in;
      out_mac_ff    <= out_mac_in;
      out_cnt_ff    <= out_cnt_in;
      out_full_ff   <= out_full_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_request_valid = out_req_ff;
   assign rsp_recovery_mac  = out_mac_ff;
   assign rsp_fail_count    = out_cnt_ff;
   assign rsp_table_full    = out_full_ff;
   assign rsp_last          = out_last_ff;

endmodule
